>>> rtl/core/assert_macros.svh
// Assertion helpers, used by xdre_queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_AT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_AT(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

>>> rtl/core/xdre_pkg.sv
`timescale 1ns / 1ps
package xdre_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] run_length;
      logic [7:0] run_value;
      logic       end_of_record;
      logic       any_changed;
   } pair_type;

   // Up to two pairs per byte; when only one, it sits in pair0.
   typedef struct packed {
      logic [1:0] count;
      pair_type   pair0;
      pair_type   pair1;
   } push_type;

endpackage

>>> rtl/core/xdre_front.sv
`timescale 1ns / 1ps
module xdre_front #(
   parameter int MAX_RUN = 255
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_old_byte,
   input  logic [7:0]         req_new_byte,
   input  logic               req_final_byte,
   input  logic               queue_room,
   output xdre_pkg::push_type push
);
   import xdre_pkg::*;

   logic [7:0] run_byte_ff, run_byte_in;
   logic [7:0] run_count_ff, run_count_in;
   logic       seen_change_ff, seen_change_in;
   logic       record_start_ff, record_start_in;

   logic       accept;
   logic [7:0] diff;
   logic       close_run;
   logic [7:0] nxt_byte;
   logic [7:0] nxt_count;
   logic       nxt_seen;
   pair_type   close_pair;
   pair_type   last_pair;

   assign req_stall = !queue_room;
   assign accept    = req_valid && queue_room;
   assign diff      = req_old_byte ^ req_new_byte;

   always_comb begin
      close_run = 1'b0;
      nxt_seen  = seen_change_ff;
      if (record_start_ff) begin
         nxt_byte  = diff;
         nxt_count = 8'd1;
         nxt_seen  = 1'b0;
      end else if (diff == run_byte_ff && run_count_ff < 8'(MAX_RUN)) begin
         nxt_byte  = run_byte_ff;
         nxt_count = run_count_ff + 8'd1;
      end else begin
         close_run = 1'b1;
         nxt_byte  = diff;
         nxt_count = 8'd1;
      end
      nxt_seen = nxt_seen || (diff != 8'd0);

      close_pair = '{run_length: run_count_ff, run_value: run_byte_ff,
                     end_of_record: 1'b0, any_changed: 1'b0};
      last_pair  = '{run_length: nxt_count, run_value: nxt_byte,
                     end_of_record: 1'b1, any_changed: nxt_seen};

      push.count = {1'b0, accept & close_run} + {1'b0, accept & req_final_byte};
      push.pair0 = close_run ? close_pair : last_pair;
      push.pair1 = last_pair;

      run_byte_in     = run_byte_ff;
      run_count_in    = run_count_ff;
      seen_change_in  = seen_change_ff;
      record_start_in = record_start_ff;
      if (accept) begin
         if (req_final_byte) begin
            run_byte_in     = 8'd0;
            run_count_in    = 8'd0;
            seen_change_in  = 1'b0;
            record_start_in = 1'b1;
         end else begin
            run_byte_in     = nxt_byte;
            run_count_in    = nxt_count;
            seen_change_in  = nxt_seen;
            record_start_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_byte_ff     <= 8'd0;
         run_count_ff    <= 8'd0;
         seen_change_ff  <= 1'b0;
         record_start_ff <= 1'b1;
      end else begin
         run_byte_ff     <= run_byte_in;
         run_count_ff    <= run_count_in;
         seen_change_ff  <= seen_change_in;
         record_start_ff <= record_start_in;
      end
   end

endmodule

>>> rtl/core/xdre_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module xdre_queue (
   input  logic               clock,
   input  logic               reset,
   input  xdre_pkg::push_type push,
   output logic               room,
   input  logic               pop,
   output logic               head_valid,
   output xdre_pkg::pair_type head
);
   import xdre_pkg::*;

   pair_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic [QUEUE_AW-1:0]   wr_next;

   // room for a two-pair transfer, judged on the registered fill only
   assign room       = count_ff <= QUEUE_CW'(QUEUE_DEPTH - 2);
   assign head_valid = count_ff != '0;
   assign head       = entry_ff[rd_ptr_ff];
   assign wr_next    = wr_ptr_ff + QUEUE_AW'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_AW'(push.count);
      rd_ptr_in = rd_ptr_ff + QUEUE_AW'(pop);
      count_in  = count_ff + QUEUE_CW'(push.count) - QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entry_ff[wr_ptr_ff] <= push.pair0;
      if (push.count == 2'd2) entry_ff[wr_next]   <= push.pair1;
   end

   `ASSERT_NEVER(a_no_overflow, clock, reset, count_ff > QUEUE_CW'(QUEUE_DEPTH), "queue overfull")
   `ASSERT_NEVER(a_no_underflow, clock, reset, pop && !head_valid, "pop from empty queue")
   `ASSERT_NEVER(a_push_fits, clock, reset, push.count != 2'd0 && !room, "push without room")
   `ASSERT_AT(a_fill_tracks, clock, reset, (push.count == 2'd0 && !pop) |=> $stable(count_ff), "fill moved while idle")

endmodule

>>> rtl/core/xdre_back.sv
`timescale 1ns / 1ps
module xdre_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  xdre_pkg::pair_type head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_run_length,
   output logic [7:0]         rsp_run_value,
   output logic               rsp_end_of_record,
   output logic               rsp_any_changed
);
   import xdre_pkg::*;

   logic     valid_ff, valid_in;
   pair_type pair_ff;
   logic     load;

   assign load     = !valid_ff || !rsp_stall;
   assign pop      = load && head_valid;
   assign valid_in = load ? head_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (pop) pair_ff <= head;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_run_length    = pair_ff.run_length;
   assign rsp_run_value     = pair_ff.run_value;
   assign rsp_end_of_record = pair_ff.end_of_record;
   assign rsp_any_changed   = pair_ff.any_changed;

endmodule

>>> rtl/core/xor_delta_rle_encoder.sv
`timescale 1ns / 1ps
// A closed pair is written into the pair queue, then loaded into the output register.
// Throughput: one byte pair per cycle while req_stall is low; pairs leave one per cycle
//   while rsp_stall is low, so a final byte that also closes a run sends out two pairs.
// req_stall follows the registered fill of the four-entry pair queue.
// Reset (synchronous): queue empty, output empty, a new record expected.
module xor_delta_rle_encoder #(
   parameter int MAX_RUN = 255
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_old_byte,
   input  logic [7:0] req_new_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_run_length,
   output logic [7:0] rsp_run_value,
   output logic       rsp_end_of_record,
   output logic       rsp_any_changed
);
   import xdre_pkg::*;

   push_type push;
   logic     room;
   logic     pop;
   logic     head_valid;
   pair_type head;

   xdre_front #(.MAX_RUN(MAX_RUN)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_old_byte   (req_old_byte),
      .req_new_byte   (req_new_byte),
      .req_final_byte (req_final_byte),
      .queue_room     (room),
      .push           (push)
   );

   xdre_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   xdre_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_run_length    (rsp_run_length),
      .rsp_run_value     (rsp_run_value),
      .rsp_end_of_record (rsp_end_of_record),
      .rsp_any_changed   (rsp_any_changed)
   );

endmodule
